@@ rtl/met_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time block.
// Used by met_cell, met_term_unit and mandelbrot_escape_time_top; depends on nothing.
package met_pkg;

    // Number format: signed fixed point with FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 24;
    localparam int Z_W       = 48;              // width of c and z
    localparam int DIGIT_W   = 16;              // multiplier digit handled by one cell
    localparam int N_CELLS   = Z_W / DIGIT_W;   // cells in the multiplier row
    localparam int PROD_W    = 2 * Z_W;         // full product width
    localparam int TERM_W    = 52;              // holds [-2^50, 2^50]
    localparam int CNT_W     = 16;              // iteration count width
    localparam int GRAY_W    = 8;
    localparam int BAIL_W    = 47;
    localparam int CFG_IDX_W = 1;

    // Term saturation limit and z range.
    localparam longint TERM_LIM = 64'sd1 <<< 50;
    localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

    // Register reset values.
    localparam logic [CNT_W-1:0] MAX_DEPTH_RESET = CNT_W'(1000);
    localparam longint BAILOUT_SCALE = 1000000;
    localparam longint BAIL_MAX      = (64'sd1 <<< BAIL_W) - 64'sd1;
    localparam logic [BAIL_W-1:0] BAILOUT_RESET =
        (BAILOUT_SCALE > (BAIL_MAX >>> FRAC_BITS)) ? BAIL_W'(BAIL_MAX)
                                                   : BAIL_W'(BAILOUT_SCALE <<< FRAC_BITS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT_SQ = CFG_IDX_W'(1);

    // Which of the three terms of an iteration a product belongs to.
    typedef enum logic [1:0] {
        TAG_XS = 2'd0,
        TAG_YS = 2'd1,
        TAG_XY = 2'd2
    } term_tag_t;

    // Product request from the controller into the multiplier row.
    typedef struct packed {
        logic             valid;
        term_tag_t        tag;
        logic             neg;
        logic [Z_W-1:0]   a_mag;
        logic [Z_W-1:0]   b_mag;
    } term_req_t;

    // Data passed from one cell to the next.
    typedef struct packed {
        logic              valid;
        term_tag_t         tag;
        logic              neg;
        logic [Z_W-1:0]    a_mag;
        logic [Z_W-1:0]    b_rest;
        logic [PROD_W-1:0] acc;
    } cell_bus_t;

    // Finished, shifted and saturated term.
    typedef struct packed {
        logic                     valid;
        term_tag_t                tag;
        logic signed [TERM_W-1:0] value;
    } term_res_t;

endpackage

@@ rtl/mandelbrot_escape_time_top.sv @@
// Top level of the Mandelbrot escape-time block: configuration registers,
// iteration controller and result register. Uses met_pkg and met_term_unit.
//
//   Channel   Ports                                   Direction  Carries
//   input     s_valid s_ready s_c_re s_c_im            in         one point c
//   result    m_valid m_ready m_iteration_count        out        count and shade
//             m_gray_level
//   config    cfg_valid cfg_ready cfg_index cfg_data   in         register write
//
// Each iteration issues the three products into the multiplier row, waits while the
// cross term passes the request register, the three cells and the two output stages,
// then runs the escape test and the z update. An iteration that escapes skips the
// z update, and a depth of zero hands over a zero count without any iteration.
// Reset is synchronous and active low; no clearing pass is needed.
// A new item is taken while the previous result still waits in the output register;
// the controller stalls only when it finishes while that register is still full.
module mandelbrot_escape_time_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [met_pkg::Z_W-1:0]    s_c_re,
    input  logic signed [met_pkg::Z_W-1:0]    s_c_im,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [met_pkg::CNT_W-1:0]         m_iteration_count,
    output logic [met_pkg::GRAY_W-1:0]        m_gray_level,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [met_pkg::BAIL_W-1:0]        cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_WAIT   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [met_pkg::CNT_W-1:0]  max_depth_reg;
    logic [met_pkg::BAIL_W-1:0] bailout_reg;

    logic signed [met_pkg::Z_W-1:0] c_re_reg, c_im_reg;
    logic signed [met_pkg::Z_W-1:0] z_re_reg, z_im_reg;
    logic signed [met_pkg::Z_W-1:0] z_re_next, z_im_next;
    logic [met_pkg::CNT_W-1:0]      k_reg, k_next;
    logic [met_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [met_pkg::CNT_W-1:0]      k_inc;

    met_pkg::term_tag_t issue_tag_reg, issue_tag_next;
    met_pkg::term_req_t req_reg, req_next;
    met_pkg::term_res_t res;

    logic signed [met_pkg::TERM_W-1:0] xs_reg, ys_reg, xy_reg;
    logic signed [met_pkg::TERM_W:0]   diff_reg;
    logic signed [met_pkg::TERM_W:0]   mag_sum;
    logic signed [met_pkg::TERM_W:0]   diff_next;
    logic                              escape;
    logic signed [met_pkg::TERM_W+1:0] re_sum;
    logic signed [met_pkg::TERM_W:0]   im_sum;

    logic [met_pkg::Z_W-1:0] zr_mag, zi_mag;

    logic                        m_valid_reg;
    logic [met_pkg::CNT_W-1:0]   m_count_reg;
    logic                        out_free;
    logic                        in_accept;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= met_pkg::MAX_DEPTH_RESET;
            bailout_reg   <= met_pkg::BAILOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                met_pkg::CFG_MAX_DEPTH:  max_depth_reg <= cfg_data[met_pkg::CNT_W-1:0];
                met_pkg::CFG_BAILOUT_SQ: bailout_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Magnitudes of the current z for the multiplier row.
    assign zr_mag = z_re_reg[met_pkg::Z_W-1] ? met_pkg::Z_W'(-z_re_reg) : z_re_reg;
    assign zi_mag = z_im_reg[met_pkg::Z_W-1] ? met_pkg::Z_W'(-z_im_reg) : z_im_reg;

    // Product request for the term being issued.
    always_comb begin
        req_next       = '0;
        req_next.valid = (state_reg == ST_ISSUE);
        req_next.tag   = issue_tag_reg;
        case (issue_tag_reg)
            met_pkg::TAG_XS: begin
                req_next.a_mag = zr_mag;
                req_next.b_mag = zr_mag;
                req_next.neg   = 1'b0;
            end
            met_pkg::TAG_YS: begin
                req_next.a_mag = zi_mag;
                req_next.b_mag = zi_mag;
                req_next.neg   = 1'b0;
            end
            met_pkg::TAG_XY: begin
                req_next.a_mag = zr_mag;
                req_next.b_mag = zi_mag;
                req_next.neg   = z_re_reg[met_pkg::Z_W-1] ^ z_im_reg[met_pkg::Z_W-1];
            end
            default: begin
                req_next.a_mag = zr_mag;
                req_next.b_mag = zr_mag;
                req_next.neg   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg <= '0;
        end else begin
            req_reg <= req_next;
        end
    end

    met_term_unit u_term_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .res     (res)
    );

    // Capture finished terms by tag.
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            case (res.tag)
                met_pkg::TAG_XS: xs_reg <= res.value;
                met_pkg::TAG_YS: ys_reg <= res.value;
                met_pkg::TAG_XY: xy_reg <= res.value;
                default: ;
            endcase
        end
    end

    // Escape test on |z|^2 and the real part difference.
    assign mag_sum   = (met_pkg::TERM_W+1)'(xs_reg) + (met_pkg::TERM_W+1)'(ys_reg);
    assign escape    = mag_sum > (met_pkg::TERM_W+1)'($signed({1'b0, bailout_reg}));
    assign diff_next = (met_pkg::TERM_W+1)'(xs_reg) - (met_pkg::TERM_W+1)'(ys_reg);

    // New z, saturated to the 48-bit signed range.
    assign re_sum = (met_pkg::TERM_W+2)'(diff_reg) + (met_pkg::TERM_W+2)'(c_re_reg);
    assign im_sum = (met_pkg::TERM_W+1)'(xy_reg) + (met_pkg::TERM_W+1)'(c_im_reg);

    always_comb begin
        if (re_sum > (met_pkg::TERM_W+2)'(met_pkg::Z_MAX)) begin
            z_re_next = met_pkg::Z_MAX;
        end else if (re_sum < (met_pkg::TERM_W+2)'(met_pkg::Z_MIN)) begin
            z_re_next = met_pkg::Z_MIN;
        end else begin
            z_re_next = met_pkg::Z_W'(re_sum);
        end
        if (im_sum > (met_pkg::TERM_W+1)'(met_pkg::Z_MAX)) begin
            z_im_next = met_pkg::Z_MAX;
        end else if (im_sum < (met_pkg::TERM_W+1)'(met_pkg::Z_MIN)) begin
            z_im_next = met_pkg::Z_MIN;
        end else begin
            z_im_next = met_pkg::Z_W'(im_sum);
        end
    end

    assign k_inc = k_reg + met_pkg::CNT_W'(1);

    // Iteration controller.
    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        issue_tag_next = issue_tag_reg;
        case (state_reg)
            ST_IDLE: begin
                k_next         = '0;
                issue_tag_next = met_pkg::TAG_XS;
                if (in_accept) begin
                    if (max_depth_reg == '0) begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                case (issue_tag_reg)
                    met_pkg::TAG_XS: issue_tag_next = met_pkg::TAG_YS;
                    met_pkg::TAG_YS: issue_tag_next = met_pkg::TAG_XY;
                    default: begin
                        issue_tag_next = met_pkg::TAG_XS;
                        state_next     = ST_WAIT;
                    end
                endcase
            end
            ST_WAIT: begin
                // The cross term is issued last, so it arrives last.
                if (res.valid && res.tag == met_pkg::TAG_XY) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (escape) begin
                    count_next = k_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                k_next = k_inc;
                if (k_inc == max_depth_reg) begin
                    count_next = max_depth_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            issue_tag_reg <= met_pkg::TAG_XS;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            issue_tag_reg <= issue_tag_next;
        end
    end

    // Point and z registers; count.
    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        if (state_reg == ST_CHECK) begin
            diff_reg <= diff_next;
        end
        if (in_accept) begin
            c_re_reg <= s_c_re;
            c_im_reg <= s_c_im;
            z_re_reg <= s_c_re;
            z_im_reg <= s_c_im;
        end else if (state_reg == ST_UPDATE) begin
            z_re_reg <= z_re_next;
            z_im_reg <= z_im_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_count_reg <= count_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign m_gray_level      = m_count_reg[met_pkg::GRAY_W-1:0];

endmodule

@@ rtl/met_cell.sv @@
// One cell of the multiplier row: multiplies the operand by one digit and
// folds it into the running sum, most significant digit first. Uses met_pkg.
module met_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  met_pkg::cell_bus_t  bus_in,
    output met_pkg::cell_bus_t  bus_out
);

    logic [met_pkg::Z_W+met_pkg::DIGIT_W-1:0] prod;
    met_pkg::cell_bus_t bus_reg;
    met_pkg::cell_bus_t bus_next;

    // Partial product of the whole operand with the top remaining digit.
    assign prod = bus_in.a_mag * bus_in.b_rest[met_pkg::Z_W-1 -: met_pkg::DIGIT_W];

    // Horner step: shift the sum up one digit and add the new partial product.
    always_comb begin
        bus_next        = bus_in;
        bus_next.acc    = {bus_in.acc[met_pkg::PROD_W-met_pkg::DIGIT_W-1:0],
                           met_pkg::DIGIT_W'(0)}
                        + met_pkg::PROD_W'(prod);
        bus_next.b_rest = {bus_in.b_rest[met_pkg::Z_W-met_pkg::DIGIT_W-1:0],
                           met_pkg::DIGIT_W'(0)};
    end

    // Reset clears the whole stage, so no stale item leaves the row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_reg <= '0;
        end else begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

@@ rtl/met_term_unit.sv @@
// Pipelined fixed-point multiplier: a row of met_cell instances followed by
// a sign stage and a floor shift and saturation stage. Uses met_pkg and met_cell.
module met_term_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  met_pkg::term_req_t req,
    output met_pkg::term_res_t res
);

    met_pkg::cell_bus_t chain [0:met_pkg::N_CELLS];

    logic                              p_valid_reg;
    met_pkg::term_tag_t                p_tag_reg;
    logic signed [met_pkg::PROD_W-1:0] p_reg;
    logic signed [met_pkg::PROD_W-1:0] p_next;
    logic signed [met_pkg::PROD_W-1:0] shifted;
    logic signed [met_pkg::TERM_W-1:0] term_next;
    met_pkg::term_res_t                res_reg;

    // Head of the row: the running sum starts at zero.
    assign chain[0] = '{valid:  req.valid,
                        tag:    req.tag,
                        neg:    req.neg,
                        a_mag:  req.a_mag,
                        b_rest: req.b_mag,
                        acc:    met_pkg::PROD_W'(0)};

    // One cell per multiplier digit.
    genvar gi;
    generate
        for (gi = 0; gi < met_pkg::N_CELLS; gi++) begin : g_cell
            met_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .bus_in  (chain[gi]),
                .bus_out (chain[gi+1])
            );
        end
    endgenerate

    // Apply the sign to the magnitude product.
    assign p_next = chain[met_pkg::N_CELLS].neg ? -$signed(chain[met_pkg::N_CELLS].acc)
                                                :  $signed(chain[met_pkg::N_CELLS].acc);

    always_ff @(posedge aclk) begin
        p_reg     <= p_next;
        p_tag_reg <= chain[met_pkg::N_CELLS].tag;
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= chain[met_pkg::N_CELLS].valid;
        end
    end

    // Floor shift: the cross term carries the factor two as one bit less shift.
    always_comb begin
        case (p_tag_reg)
            met_pkg::TAG_XS: shifted = p_reg >>> met_pkg::FRAC_BITS;
            met_pkg::TAG_YS: shifted = p_reg >>> met_pkg::FRAC_BITS;
            met_pkg::TAG_XY: shifted = p_reg >>> (met_pkg::FRAC_BITS - 1);
            default:         shifted = p_reg >>> met_pkg::FRAC_BITS;
        endcase
    end

    // Saturate to [-2^50, 2^50].
    always_comb begin
        if (shifted > met_pkg::PROD_W'(met_pkg::TERM_LIM)) begin
            term_next = met_pkg::TERM_W'(met_pkg::TERM_LIM);
        end else if (shifted < -met_pkg::PROD_W'(met_pkg::TERM_LIM)) begin
            term_next = -met_pkg::TERM_W'(met_pkg::TERM_LIM);
        end else begin
            term_next = met_pkg::TERM_W'(shifted);
        end
    end

    always_ff @(posedge aclk) begin
        res_reg.value <= term_next;
        res_reg.tag   <= p_tag_reg;
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else begin
            res_reg.valid <= p_valid_reg;
        end
    end

    assign res = res_reg;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for mandelbrot_escape_time_top: drives points and register
// writes, predicts each escape count, and checks every result item. Depends on met_pkg.
module testbench;

    // Constants taken from the shared package.
    localparam int FRAC_BITS = met_pkg::FRAC_BITS;
    localparam int Z_W       = met_pkg::Z_W;
    localparam int PROD_W    = met_pkg::PROD_W;
    localparam int CNT_W     = met_pkg::CNT_W;
    localparam int GRAY_W    = met_pkg::GRAY_W;
    localparam int BAIL_W    = met_pkg::BAIL_W;
    localparam int CFG_IDX_W = met_pkg::CFG_IDX_W;
    localparam longint TERM_LIM = met_pkg::TERM_LIM;
    localparam logic signed [Z_W-1:0] Z_MAX = met_pkg::Z_MAX;
    localparam logic signed [Z_W-1:0] Z_MIN = met_pkg::Z_MIN;
    localparam logic [CNT_W-1:0] MAX_DEPTH_RESET = met_pkg::MAX_DEPTH_RESET;
    localparam logic [BAIL_W-1:0] BAILOUT_RESET = met_pkg::BAILOUT_RESET;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH  = met_pkg::CFG_MAX_DEPTH;
    localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT_SQ = met_pkg::CFG_BAILOUT_SQ;

    // The value one in the fixed-point format.
    localparam longint FX_ONE = 64'sd1 <<< FRAC_BITS;

    typedef struct {
        logic [CNT_W-1:0]  count;
        logic [GRAY_W-1:0] gray;
    } escape_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [Z_W-1:0]      s_c_re = '0;
    logic signed [Z_W-1:0]      s_c_im = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [CNT_W-1:0]           m_iteration_count;
    logic [GRAY_W-1:0]          m_gray_level;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [BAIL_W-1:0]          cfg_data = '0;

    // Local copy of the configuration registers, updated on each accepted write.
    logic [CNT_W-1:0]           depth_limit = MAX_DEPTH_RESET;
    logic [BAIL_W-1:0]          bailout_limit = BAILOUT_RESET;

    escape_result_t             pending_results[$];
    escape_result_t             oldest;
    int                         failures = 0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;
    logic signed [Z_W-1:0]      corner_values[5] =
        '{Z_MAX, Z_MIN, Z_W'(0), Z_W'(-1), Z_W'(FX_ONE)};

    mandelbrot_escape_time_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_c_re            (s_c_re),
        .s_c_im            (s_c_im),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_gray_level      (m_gray_level),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Product of two z components, floored after the shift and clamped to the term range.
    function automatic longint fixed_product(input logic signed [Z_W-1:0] a, b,
                                             input int shift);
        logic signed [PROD_W-1:0] wide_a, wide_b, prod;
        wide_a = a;
        wide_b = b;
        prod = (wide_a * wide_b) >>> shift;
        if (prod > TERM_LIM) return TERM_LIM;
        if (prod < -TERM_LIM) return -TERM_LIM;
        return longint'(prod);
    endfunction

    // Clamp an updated z component to the 48-bit signed range.
    function automatic logic signed [Z_W-1:0] saturate_z(input longint v);
        if (v > Z_MAX) return Z_MAX;
        if (v < Z_MIN) return Z_MIN;
        return v[Z_W-1:0];
    endfunction

    // Escape count and shade of one point under the current register settings.
    function automatic escape_result_t escape_time(input logic signed [Z_W-1:0] c_re, c_im);
        logic signed [Z_W-1:0] z_re, z_im;
        longint xs, ys, xy, bail;
        int count;
        escape_result_t res;
        z_re = c_re;
        z_im = c_im;
        bail = longint'({17'b0, bailout_limit});
        count = depth_limit;
        for (int k = 0; k < depth_limit; k++) begin
            xs = fixed_product(z_re, z_re, FRAC_BITS);
            ys = fixed_product(z_im, z_im, FRAC_BITS);
            xy = fixed_product(z_re, z_im, FRAC_BITS - 1);
            if (xs + ys > bail) begin
                count = k;
                break;
            end
            z_re = saturate_z(xs - ys + c_re);
            z_im = saturate_z(xy + c_im);
        end
        res.count = count[CNT_W-1:0];
        res.gray = count[GRAY_W-1:0];
        return res;
    endfunction

    function automatic logic [Z_W-1:0] random_bits48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[Z_W-1:0];
    endfunction

    // Offer one point, with random idle cycles first, and record its prediction.
    task automatic send_point(input logic signed [Z_W-1:0] re, im);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_c_re <= re;
        s_c_im <= im;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(escape_time(re, im));
    endtask

    // Stop offering items and wait until every predicted result has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [BAIL_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_MAX_DEPTH) begin
            depth_limit = value[CNT_W-1:0];
        end else begin
            bailout_limit = value;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Register values after reset: a bounded point, fast escapes and saturated corners.
    task automatic test_reset_values();
        send_point(Z_W'(0), Z_W'(0));
        send_point(Z_W'(FX_ONE), Z_W'(0));
        send_point(Z_MAX, Z_MAX);
        send_point(Z_MIN, Z_MIN);
        send_point(Z_MIN, Z_MAX);
        // The orbit of -2 settles at 2 and never escapes.
        send_point(Z_W'(-2 * FX_ONE), Z_W'(0));
        // Tiny negative values exercise the floor rounding of the products.
        send_point(Z_W'(-1), Z_W'(-1));
        wait_idle();
    endtask

    // A depth of zero runs no iteration at all.
    task automatic test_zero_depth();
        write_register(CFG_MAX_DEPTH, BAIL_W'(0));
        send_point(Z_W'(0), Z_W'(0));
        send_point(Z_MAX, Z_MIN);
        wait_idle();
    endtask

    // With a zero bailout a nonzero square term escapes at once.
    task automatic test_zero_bailout();
        write_register(CFG_MAX_DEPTH, BAIL_W'(5));
        write_register(CFG_BAILOUT_SQ, BAIL_W'(0));
        send_point(Z_W'(0), Z_W'(0));
        // The square of this value is exactly one least significant bit.
        send_point(Z_W'(4096), Z_W'(0));
        send_point(Z_W'(-1), Z_W'(-1));
        send_point(Z_W'(0), Z_MIN);
        wait_idle();
    endtask

    // The largest bailout is exceeded only when the two square terms sum to 2^47 or more.
    task automatic test_full_bailout();
        write_register(CFG_MAX_DEPTH, BAIL_W'(40));
        write_register(CFG_BAILOUT_SQ, {BAIL_W{1'b1}});
        send_point(Z_MAX, Z_W'(0));
        send_point(Z_W'(2 * FX_ONE), Z_W'(2 * FX_ONE));
        send_point(Z_W'(FX_ONE / 4), Z_W'(0));
        wait_idle();
    endtask

    // The deepest limit, with points that leave quickly to keep the run short.
    task automatic test_deepest_limit();
        write_register(CFG_MAX_DEPTH, {BAIL_W{1'b1}});
        write_register(CFG_BAILOUT_SQ, BAIL_W'(4 * FX_ONE));
        send_point(Z_W'(2 * FX_ONE), Z_W'(0));
        send_point(Z_W'(FX_ONE), Z_W'(FX_ONE));
        send_point(Z_MIN, Z_W'(0));
        wait_idle();
    endtask

    // Counts above 255 wrap the gray level.
    task automatic test_gray_wrap();
        write_register(CFG_MAX_DEPTH, BAIL_W'(300));
        send_point(Z_W'(0), Z_W'(0));
        wait_idle();
        write_register(CFG_MAX_DEPTH, BAIL_W'(256));
        send_point(Z_W'(0), Z_W'(0));
        wait_idle();
    endtask

    // Random points under several random settings, reconfigured between blocks of items.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int unsigned pick;
        longint re, im;
        logic [31:0] r;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (4) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                write_register(CFG_MAX_DEPTH, BAIL_W'($urandom_range(1, 32)));
            end else if (pick < 95) begin
                write_register(CFG_MAX_DEPTH, BAIL_W'($urandom_range(33, 120)));
            end else begin
                write_register(CFG_MAX_DEPTH, BAIL_W'(0));
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                write_register(CFG_BAILOUT_SQ, BAIL_W'(4 * FX_ONE));
            end else if (pick < 60) begin
                write_register(CFG_BAILOUT_SQ, BAIL_W'(longint'($urandom_range(0, 64)) * FX_ONE));
            end else if (pick < 80) begin
                write_register(CFG_BAILOUT_SQ, BAIL_W'(random_bits48()));
            end else if (pick < 90) begin
                write_register(CFG_BAILOUT_SQ, BAIL_W'($urandom_range(0, 1000)));
            end else begin
                write_register(CFG_BAILOUT_SQ, {BAIL_W{1'b1}});
            end
            repeat (50) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // Region around the set: real in [-2.5, 1.0], imaginary in [-1.25, 1.25].
                    re = longint'($urandom_range(0, 7 * (FX_ONE / 2))) - 5 * (FX_ONE / 2);
                    im = longint'($urandom_range(0, 5 * (FX_ONE / 2))) - 5 * (FX_ONE / 4);
                end else if (pick < 75) begin
                    r = $urandom;
                    re = longint'($signed(r[27:0]));
                    r = $urandom;
                    im = longint'($signed(r[27:0]));
                end else if (pick < 90) begin
                    re = longint'(random_bits48());
                    im = longint'(random_bits48());
                end else begin
                    re = corner_values[$urandom_range(0, 4)];
                    im = corner_values[$urandom_range(0, 4)];
                end
                send_point(Z_W'(re), Z_W'(im));
            end
            wait_idle();
        end
    endtask

    // Receiver back-pressure changes at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: iteration_count %0d", m_iteration_count);
                failures++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_iteration_count !== oldest.count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           oldest.count, m_iteration_count);
                    failures++;
                end
                if (m_gray_level !== oldest.gray) begin
                    $error("gray_level: expected %0d, got %0d", oldest.gray, m_gray_level);
                    failures++;
                end
            end
        end
    end

    // Main sequence: reset, directed checks, then three rounds of random traffic.
    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 76;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_zero_depth();
        test_zero_bailout();
        test_full_bailout();
        test_deepest_limit();
        test_gray_wrap();
        test_random_traffic(11, 76);
        test_random_traffic(76, 11);
        test_random_traffic(0, 0);
        repeat (50) @(posedge aclk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
